[design/rce_pkg.sv]
// Shared types and constants for the residual cokurtosis element block.
package rce_pkg;

  localparam int DATA_W          = 32;
  localparam int IDX_W           = 4;
  localparam int COL_W           = 12;
  localparam int CNT_W           = 5;
  // compare width: holds any index, any asset count and MAX_ASSETS up to 32
  localparam int CMP_W           = 6;
  localparam int MAX_ASSETS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ASSET_COUNT_RST = 16;

  typedef enum logic [1:0] {
    OP_COV_WR = 2'd0,
    OP_M2_WR  = 2'd1,
    OP_M4_WR  = 2'd2,
    OP_QUERY  = 2'd3
  } rce_op_e;

  // equality pattern of the four query indices
  typedef enum logic [2:0] {
    CLS_ZERO   = 3'd0,
    CLS_ALL    = 3'd1,
    CLS_THREE  = 3'd2,
    CLS_PAIRS  = 3'd3,
    CLS_SINGLE = 3'd4
  } rce_class_e;

  // operand selection: cov0 = cov(cr,cc), cov1 = cov(q,q), m2_0 = m2[p], m2_1 = m2[q], m4 = m4[p]
  typedef struct packed {
    rce_class_e       cls;
    logic [IDX_W-1:0] cr;
    logic [IDX_W-1:0] cc;
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
  } rce_sel_t;

  typedef struct packed {
    logic cov_we;
    logic m2_we;
    logic m4_we;
  } rce_wr_t;

  typedef struct packed {
    logic             valid;
    rce_class_e       cls;
    logic [IDX_W-1:0] row;
    logic [COL_W-1:0] col;
  } rce_ctl_t;

endpackage

[design/rce_decode.sv]
// Query index pattern classifier and store operand selection.
module rce_decode (
  input  logic [rce_pkg::IDX_W-1:0] i_i,
  input  logic [rce_pkg::IDX_W-1:0] j_i,
  input  logic [rce_pkg::IDX_W-1:0] k_i,
  input  logic [rce_pkg::IDX_W-1:0] l_i,
  output rce_pkg::rce_sel_t         sel_o
);

  logic eq_ij, eq_ik, eq_il, eq_jk, eq_jl, eq_kl;

  assign eq_ij = (i_i == j_i);
  assign eq_ik = (i_i == k_i);
  assign eq_il = (i_i == l_i);
  assign eq_jk = (j_i == k_i);
  assign eq_jl = (j_i == l_i);
  assign eq_kl = (k_i == l_i);

  always_comb begin
    sel_o     = '0;
    sel_o.cls = rce_pkg::CLS_ZERO;
    priority if (eq_ij && eq_ik && eq_il) begin
      sel_o.cls = rce_pkg::CLS_ALL;
      sel_o.cr  = i_i;
      sel_o.cc  = i_i;
      sel_o.p   = i_i;
    end else if (eq_ij && eq_ik) begin
      sel_o.cls = rce_pkg::CLS_THREE;
      sel_o.cr  = i_i;
      sel_o.cc  = l_i;
      sel_o.p   = i_i;
    end else if (eq_ij && eq_il) begin
      sel_o.cls = rce_pkg::CLS_THREE;
      sel_o.cr  = i_i;
      sel_o.cc  = k_i;
      sel_o.p   = i_i;
    end else if (eq_ik && eq_il) begin
      sel_o.cls = rce_pkg::CLS_THREE;
      sel_o.cr  = i_i;
      sel_o.cc  = j_i;
      sel_o.p   = i_i;
    end else if (eq_jk && eq_jl) begin
      sel_o.cls = rce_pkg::CLS_THREE;
      sel_o.cr  = j_i;
      sel_o.cc  = i_i;
      sel_o.p   = j_i;
    end else if (eq_ij && eq_kl) begin
      sel_o.cls = rce_pkg::CLS_PAIRS;
      sel_o.cr  = i_i;
      sel_o.cc  = i_i;
      sel_o.p   = i_i;
      sel_o.q   = k_i;
    end else if ((eq_ik && eq_jl) || (eq_il && eq_jk)) begin
      sel_o.cls = rce_pkg::CLS_PAIRS;
      sel_o.cr  = i_i;
      sel_o.cc  = i_i;
      sel_o.p   = i_i;
      sel_o.q   = j_i;
    end else if (eq_ij) begin
      sel_o.cls = rce_pkg::CLS_SINGLE;
      sel_o.cr  = k_i;
      sel_o.cc  = l_i;
      sel_o.p   = i_i;
    end else if (eq_ik) begin
      sel_o.cls = rce_pkg::CLS_SINGLE;
      sel_o.cr  = j_i;
      sel_o.cc  = l_i;
      sel_o.p   = i_i;
    end else if (eq_il) begin
      sel_o.cls = rce_pkg::CLS_SINGLE;
      sel_o.cr  = j_i;
      sel_o.cc  = k_i;
      sel_o.p   = i_i;
    end else if (eq_jk) begin
      sel_o.cls = rce_pkg::CLS_SINGLE;
      sel_o.cr  = i_i;
      sel_o.cc  = l_i;
      sel_o.p   = j_i;
    end else if (eq_jl) begin
      sel_o.cls = rce_pkg::CLS_SINGLE;
      sel_o.cr  = i_i;
      sel_o.cc  = k_i;
      sel_o.p   = j_i;
    end else if (eq_kl) begin
      sel_o.cls = rce_pkg::CLS_SINGLE;
      sel_o.cr  = i_i;
      sel_o.cc  = j_i;
      sel_o.p   = k_i;
    end else begin
      sel_o.cls = rce_pkg::CLS_ZERO;
    end
  end

endmodule

[design/rce_store.sv]
// Covariance and residual moment memories, one write port, registered reads.
module rce_store #(
  parameter  int MAX_ASSETS = rce_pkg::MAX_ASSETS_DEF,
  localparam int AW         = $clog2(MAX_ASSETS),
  localparam int CAW        = $clog2(MAX_ASSETS * MAX_ASSETS)
) (
  input  logic                              clk_i,
  input  rce_pkg::rce_wr_t                  wr_i,
  input  logic [CAW-1:0]                    cov_waddr_i,
  input  logic [AW-1:0]                     m_waddr_i,
  input  logic signed [rce_pkg::DATA_W-1:0] wdata_i,
  input  logic [CAW-1:0]                    cov_raddr0_i,
  input  logic [CAW-1:0]                    cov_raddr1_i,
  input  logic [AW-1:0]                     m2_raddr0_i,
  input  logic [AW-1:0]                     m2_raddr1_i,
  input  logic [AW-1:0]                     m4_raddr_i,
  output logic signed [rce_pkg::DATA_W-1:0] cov0_o,
  output logic signed [rce_pkg::DATA_W-1:0] cov1_o,
  output logic signed [rce_pkg::DATA_W-1:0] m2_0_o,
  output logic signed [rce_pkg::DATA_W-1:0] m2_1_o,
  output logic signed [rce_pkg::DATA_W-1:0] m4_o
);

  logic signed [rce_pkg::DATA_W-1:0] cov_mem [MAX_ASSETS * MAX_ASSETS];
  logic signed [rce_pkg::DATA_W-1:0] m2_mem  [MAX_ASSETS];
  logic signed [rce_pkg::DATA_W-1:0] m4_mem  [MAX_ASSETS];

  // read-before-write: a read in the cycle after a write sees it
  always_ff @(posedge clk_i) begin
    if (wr_i.cov_we) begin
      cov_mem[cov_waddr_i] <= wdata_i;
    end
    cov0_o <= cov_mem[cov_raddr0_i];
    cov1_o <= cov_mem[cov_raddr1_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.m2_we) begin
      m2_mem[m_waddr_i] <= wdata_i;
    end
    m2_0_o <= m2_mem[m2_raddr0_i];
    m2_1_o <= m2_mem[m2_raddr1_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.m4_we) begin
      m4_mem[m_waddr_i] <= wdata_i;
    end
    m4_o <= m4_mem[m4_raddr_i];
  end

endmodule

[design/rce_arith.sv]
// Fixed-point product, scaling and saturation pipeline (three register stages).
module rce_arith #(
  parameter int FRAC_BITS = rce_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rce_pkg::rce_ctl_t                 ctl_i,
  input  logic signed [rce_pkg::DATA_W-1:0] cov0_i,
  input  logic signed [rce_pkg::DATA_W-1:0] cov1_i,
  input  logic signed [rce_pkg::DATA_W-1:0] m2_0_i,
  input  logic signed [rce_pkg::DATA_W-1:0] m2_1_i,
  input  logic signed [rce_pkg::DATA_W-1:0] m4_i,
  output logic                              valid_o,
  output logic signed [rce_pkg::DATA_W-1:0] value_o,
  output logic [rce_pkg::IDX_W-1:0]         row_o,
  output logic [rce_pkg::COL_W-1:0]         col_o,
  output logic                              sat_o
);

  localparam int DW = rce_pkg::DATA_W;
  localparam int PW = 2 * DW;
  // shifted product plus headroom for the x6 scale and the final sum
  localparam int TW = PW - FRAC_BITS + 4;

  // product stage
  logic signed [DW-1:0] mb;
  logic signed [PW-1:0] p1_d, p2_d, p3_d;
  logic signed [PW-1:0] p1_q, p2_q, p3_q;
  logic signed [DW-1:0] m4_q;
  rce_pkg::rce_ctl_t    ctl3_q;

  // term stage
  logic signed [TW-1:0] s1, s2, s3;
  logic signed [TW-1:0] t1_d, t2_d, t1_q, t2_q;
  rce_pkg::rce_ctl_t    ctl4_q;

  // output stage
  logic signed [TW-1:0]    sum;
  logic [TW-DW:0]          sum_hi;
  logic signed [DW-1:0]    value_d, value_q;
  logic                    sat_d, sat_q;
  logic                    valid_q;
  logic [rce_pkg::IDX_W-1:0] row_q;
  logic [rce_pkg::COL_W-1:0] col_q;

  always_comb begin
    mb   = (ctl_i.cls == rce_pkg::CLS_PAIRS) ? m2_1_i : m2_0_i;
    p1_d = cov0_i * mb;
    p2_d = cov1_i * m2_0_i;
    p3_d = m2_0_i * m2_1_i;
  end

  // arithmetic shift floors, matching round toward minus infinity
  always_comb begin
    s1 = TW'(p1_q >>> FRAC_BITS);
    s2 = TW'(p2_q >>> FRAC_BITS);
    s3 = TW'(p3_q >>> FRAC_BITS);
    unique case (ctl3_q.cls)
      rce_pkg::CLS_ALL: begin
        t1_d = (s1 <<< 2) + (s1 <<< 1);
        t2_d = TW'(m4_q);
      end
      rce_pkg::CLS_THREE: begin
        t1_d = (s1 <<< 1) + s1;
        t2_d = '0;
      end
      rce_pkg::CLS_PAIRS: begin
        t1_d = s1;
        t2_d = s2 + s3;
      end
      rce_pkg::CLS_SINGLE: begin
        t1_d = s1;
        t2_d = '0;
      end
      default: begin
        t1_d = '0;
        t2_d = '0;
      end
    endcase
  end

  always_comb begin
    sum    = t1_q + t2_q;
    sum_hi = sum[TW-1:DW-1];
    if (sum_hi == '0 || sum_hi == '1) begin
      value_d = sum[DW-1:0];
      sat_d   = 1'b0;
    end else begin
      value_d = sum[TW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      sat_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q  <= '0;
      ctl4_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      ctl3_q  <= ctl_i;
      ctl4_q  <= ctl3_q;
      valid_q <= ctl4_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p1_d;
    p2_q    <= p2_d;
    p3_q    <= p3_d;
    m4_q    <= m4_i;
    t1_q    <= t1_d;
    t2_q    <= t2_d;
    value_q <= value_d;
    sat_q   <= sat_d;
    row_q   <= ctl4_q.row;
    col_q   <= ctl4_q.col;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign row_o   = row_q;
  assign col_o   = col_q;
  assign sat_o   = sat_q;

endmodule

[design/residual_cokurtosis_element.sv]
// Top level: input stage, asset count register, store addressing and pipeline hookup.
// A query's result strobes after the input register, memory read, multiply, scale, add
// and saturate steps, in that order.
// Throughput: one request per cycle; busy_o stays low, writes and queries interleave freely.
// Reset clears the pipeline valid bits and sets the asset count to 16 (clamped to MAX_ASSETS);
// memory contents are undefined until written. Results cannot be held off by the receiver.
module residual_cokurtosis_element #(
  parameter int MAX_ASSETS = rce_pkg::MAX_ASSETS_DEF,
  parameter int FRAC_BITS  = rce_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        op_i,
  input  logic [rce_pkg::IDX_W-1:0]         idx_a_i,
  input  logic [rce_pkg::IDX_W-1:0]         idx_b_i,
  input  logic [rce_pkg::IDX_W-1:0]         idx_c_i,
  input  logic [rce_pkg::IDX_W-1:0]         idx_d_i,
  input  logic signed [rce_pkg::DATA_W-1:0] write_value_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rce_pkg::CNT_W-1:0]         cfg_asset_count_i,
  output logic                              result_valid_o,
  output logic signed [rce_pkg::DATA_W-1:0] element_value_o,
  output logic [rce_pkg::IDX_W-1:0]         matrix_row_o,
  output logic [rce_pkg::COL_W-1:0]         matrix_column_o,
  output logic                              saturated_o
);

  localparam int AW    = $clog2(MAX_ASSETS);
  localparam int CAW   = $clog2(MAX_ASSETS * MAX_ASSETS);
  localparam int NW    = $clog2(MAX_ASSETS + 1);
  localparam int NNW   = 2 * NW;
  localparam int CMPW  = rce_pkg::CMP_W;
  localparam int COLW  = rce_pkg::COL_W;
  localparam int N_RST = (rce_pkg::ASSET_COUNT_RST > MAX_ASSETS) ? MAX_ASSETS
                                                                 : rce_pkg::ASSET_COUNT_RST;

  logic accept;

  // asset count, clamped and squared when written
  logic [CMPW-1:0] cfg_cnt;
  logic [NW-1:0]   n_eff_d, n_eff_q;
  logic [NNW-1:0]  nn_d, nn_q;

  // input stage
  logic                          s1_valid_q;
  rce_pkg::rce_op_e              s1_op_q;
  logic [rce_pkg::IDX_W-1:0]     s1_a_q, s1_b_q, s1_c_q, s1_d_q;
  logic signed [rce_pkg::DATA_W-1:0] s1_wv_q;

  rce_pkg::rce_sel_t sel;
  rce_pkg::rce_wr_t  wr;
  rce_pkg::rce_ctl_t ctl_d, s2_ctl_q;
  logic              in_range, a_ok, b_ok;

  logic [CAW-1:0] cov_waddr, cov_raddr0, cov_raddr1;
  logic [AW-1:0]  m_waddr, m2_raddr0, m2_raddr1;

  logic signed [rce_pkg::DATA_W-1:0] cov0, cov1, m2_0, m2_1, m4;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_comb begin
    cfg_cnt = CMPW'(cfg_asset_count_i);
    priority if (cfg_cnt == '0) begin
      n_eff_d = NW'(1);
    end else if (cfg_cnt > CMPW'(MAX_ASSETS)) begin
      n_eff_d = NW'(MAX_ASSETS);
    end else begin
      n_eff_d = NW'(cfg_cnt);
    end
    nn_d = NNW'(n_eff_d) * NNW'(n_eff_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_eff_q <= NW'(N_RST);
      nn_q    <= NNW'(N_RST * N_RST);
    end else if (cfg_valid_i && cfg_ready_o) begin
      n_eff_q <= n_eff_d;
      nn_q    <= nn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_ctl_q   <= '0;
    end else begin
      s1_valid_q <= accept;
      s2_ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= rce_pkg::rce_op_e'(op_i);
      s1_a_q  <= idx_a_i;
      s1_b_q  <= idx_b_i;
      s1_c_q  <= idx_c_i;
      s1_d_q  <= idx_d_i;
      s1_wv_q <= write_value_i;
    end
  end

  rce_decode u_decode (
    .i_i   (s1_a_q),
    .j_i   (s1_b_q),
    .k_i   (s1_c_q),
    .l_i   (s1_d_q),
    .sel_o (sel)
  );

  always_comb begin
    in_range = (CMPW'(s1_a_q) < CMPW'(n_eff_q)) && (CMPW'(s1_b_q) < CMPW'(n_eff_q)) &&
               (CMPW'(s1_c_q) < CMPW'(n_eff_q)) && (CMPW'(s1_d_q) < CMPW'(n_eff_q));
    a_ok     = CMPW'(s1_a_q) < CMPW'(MAX_ASSETS);
    b_ok     = CMPW'(s1_b_q) < CMPW'(MAX_ASSETS);

    ctl_d.valid = s1_valid_q && (s1_op_q == rce_pkg::OP_QUERY) && in_range;
    ctl_d.cls   = sel.cls;
    ctl_d.row   = s1_c_q;
    // column wraps to its low bits
    ctl_d.col   = COLW'(COLW'(s1_a_q) * COLW'(nn_q) + COLW'(s1_b_q) * COLW'(n_eff_q) +
                        COLW'(s1_d_q));

    wr.cov_we = s1_valid_q && (s1_op_q == rce_pkg::OP_COV_WR) && a_ok && b_ok;
    wr.m2_we  = s1_valid_q && (s1_op_q == rce_pkg::OP_M2_WR) && a_ok;
    wr.m4_we  = s1_valid_q && (s1_op_q == rce_pkg::OP_M4_WR) && a_ok;

    cov_waddr  = CAW'(CAW'(s1_a_q) * CAW'(MAX_ASSETS) + CAW'(s1_b_q));
    m_waddr    = AW'(s1_a_q);
    cov_raddr0 = CAW'(CAW'(sel.cr) * CAW'(MAX_ASSETS) + CAW'(sel.cc));
    cov_raddr1 = CAW'(CAW'(sel.q) * CAW'(MAX_ASSETS) + CAW'(sel.q));
    m2_raddr0  = AW'(sel.p);
    m2_raddr1  = AW'(sel.q);
  end

  rce_store #(
    .MAX_ASSETS (MAX_ASSETS)
  ) u_store (
    .clk_i        (clk_i),
    .wr_i         (wr),
    .cov_waddr_i  (cov_waddr),
    .m_waddr_i    (m_waddr),
    .wdata_i      (s1_wv_q),
    .cov_raddr0_i (cov_raddr0),
    .cov_raddr1_i (cov_raddr1),
    .m2_raddr0_i  (m2_raddr0),
    .m2_raddr1_i  (m2_raddr1),
    .m4_raddr_i   (m2_raddr0),
    .cov0_o       (cov0),
    .cov1_o       (cov1),
    .m2_0_o       (m2_0),
    .m2_1_o       (m2_1),
    .m4_o         (m4)
  );

  rce_arith #(
    .FRAC_BITS (FRAC_BITS)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s2_ctl_q),
    .cov0_i  (cov0),
    .cov1_i  (cov1),
    .m2_0_i  (m2_0),
    .m2_1_i  (m2_1),
    .m4_i    (m4),
    .valid_o (result_valid_o),
    .value_o (element_value_o),
    .row_o   (matrix_row_o),
    .col_o   (matrix_column_o),
    .sat_o   (saturated_o)
  );

endmodule
